// File: design/bhsv_pkg.sv
// ----------------------------------------------------------------------------
// bhsv_pkg: shared types and constants for the book header stream validator
// Line phases, character phases, section codes and the classified-byte record
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bhsv_pkg;

  // Line phase of the header parser.
  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_VERSION = 3'd1,
    PH_PCOUNT  = 3'd2,
    PH_VCOUNT  = 3'd3,
    PH_VARIANT = 3'd4,
    PH_PREDEF  = 3'd5,
    PH_COMMENT = 3'd6,
    PH_FAIL    = 3'd7
  } lp_t;

  typedef logic [2:0] cp_t;

  // Version line character phases.
  localparam cp_t V_START = 3'd0;
  localparam cp_t V_ZERO  = 3'd1;
  localparam cp_t V_INT   = 3'd2;
  localparam cp_t V_DOT   = 3'd3;
  localparam cp_t V_FZERO = 3'd4;
  localparam cp_t V_FRAC  = 3'd5;

  // Count line character phases.
  localparam cp_t N_START = 3'd0;
  localparam cp_t N_ZERO  = 3'd1;
  localparam cp_t N_DIG   = 3'd2;

  // Predef line character phases.
  localparam cp_t P_START = 3'd0;
  localparam cp_t P_CHAR  = 3'd1;
  localparam cp_t P_SPACE = 3'd2;

  // Section tag for separators and for bytes after a rejection.
  localparam logic [2:0] SECT_NONE = 3'd0;

  localparam logic [7:0] BYTE_END   = 8'h00;
  localparam logic [7:0] BYTE_NL    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DOT   = 8'h2E;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  localparam logic [2:0] MAGIC_LEN = 3'd4;

  // Expected characters of the magic line "@PG@".
  function automatic logic [7:0] magic_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h40;
      2'd1:    c = 8'h50;
      2'd2:    c = 8'h47;
      2'd3:    c = 8'h40;
      default: c = 8'h40;
    endcase
    return c;
  endfunction

  // One header byte after classification by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       is_nl;
    logic       is_dig;
    logic       is_nz;
    logic       is_zero;
    logic       is_dot;
    logic       is_space;
    logic       var_ok;
  } cls_t;

  // One result transaction.
  typedef struct packed {
    logic [9:0] predef_total;
    logic [9:0] variant_total;
    logic       header_ok;
    logic       end_of_header;
    logic       failed;
    logic [2:0] section;
  } res_t;

endpackage

// File: design/bhsv_front.sv
// ----------------------------------------------------------------------------
// bhsv_front: input byte classifier
// Decodes each incoming byte into the character classes the parser needs.
// ----------------------------------------------------------------------------
module bhsv_front (
  input  logic [7:0]    data_byte,
  output bhsv_pkg::cls_t cls
);

  always_comb begin
    cls.data     = data_byte;
    cls.is_end   = (data_byte == bhsv_pkg::BYTE_END);
    cls.is_nl    = (data_byte == bhsv_pkg::BYTE_NL);
    cls.is_dig   = (data_byte >= bhsv_pkg::BYTE_ZERO) && (data_byte <= bhsv_pkg::BYTE_NINE);
    cls.is_zero  = (data_byte == bhsv_pkg::BYTE_ZERO);
    cls.is_nz    = cls.is_dig && !cls.is_zero;
    cls.is_dot   = (data_byte == bhsv_pkg::BYTE_DOT);
    cls.is_space = (data_byte == bhsv_pkg::BYTE_SPACE);
    // Printable, not space, not uppercase.
    cls.var_ok   = (data_byte >= 8'h21) && (data_byte <= 8'h7E) &&
                   !((data_byte >= 8'h41) && (data_byte <= 8'h5A));
  end

endmodule

// File: design/bhsv_queue.sv
// ----------------------------------------------------------------------------
// bhsv_queue: two-entry queue of classified bytes
// Decouples the classifier from the parser so each side stalls on its own.
// ----------------------------------------------------------------------------
module bhsv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bhsv_pkg::cls_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bhsv_pkg::cls_t pop_data
);

  bhsv_pkg::cls_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/bhsv_back.sv
// ----------------------------------------------------------------------------
// bhsv_back: header parser and result register
// Runs the line and character state machine on one classified byte per cycle
// while the output side is not stalled, and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module bhsv_back #(
  parameter int MAX_COUNT = 1023
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  bhsv_pkg::cls_t q_data,
  output logic           q_pop,
  output logic           res_valid,
  output bhsv_pkg::res_t res,
  input  logic           res_ready
);

  // Counter width holds the saturated value MAX_COUNT + 1.
  localparam int CW = $clog2(MAX_COUNT + 2);
  localparam int PW = CW + 4;
  localparam int EW = (CW > 10) ? CW : 10;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_COUNT);
  localparam logic [CW-1:0] CNT_SAT = CW'(MAX_COUNT + 1);

  bhsv_pkg::lp_t  lp_r, lp_nxt, lp_a;
  bhsv_pkg::cp_t  cp_r, cp_nxt, cp_a;
  logic [2:0]     mpos_r, mpos_nxt, mpos_a;
  logic [CW-1:0]  acc_r, acc_nxt, acc_a;
  logic [CW-1:0]  pleft_r, pleft_nxt, pleft_a;
  logic [CW-1:0]  vleft_r, vleft_nxt, vleft_a;
  logic [CW-1:0]  pseen_r, pseen_nxt, pseen_a;
  logic [CW-1:0]  vseen_r, vseen_nxt, vseen_a;
  logic           open_r, open_nxt, open_a;

  logic           out_valid_r, out_valid_nxt;
  bhsv_pkg::res_t out_r;
  bhsv_pkg::res_t res_nxt;

  logic [PW-1:0]  prod;
  logic [CW-1:0]  digit_acc;
  logic [CW-1:0]  pleft_dec;
  logic [CW-1:0]  vleft_dec;
  logic           is_sep;
  logic [EW-1:0]  vseen_ext;
  logic [EW-1:0]  pseen_ext;

  assign is_sep = q_data.is_end || q_data.is_nl;
  assign q_pop  = q_valid && (!out_valid_r || res_ready);

  // acc * 10 + digit, saturated above MAX_COUNT.
  always_comb begin
    prod = (PW'(acc_r) << 3) + (PW'(acc_r) << 1) + PW'(q_data.data[3:0]);
    digit_acc = (prod > PW'(MAX_COUNT)) ? CNT_SAT : prod[CW-1:0];
  end

  assign pleft_dec = pleft_r - CW'(1);
  assign vleft_dec = vleft_r - CW'(1);

  // Parser next-state logic: the state right after this byte.
  always_comb begin
    lp_a    = lp_r;
    cp_a    = cp_r;
    mpos_a  = mpos_r;
    acc_a   = acc_r;
    pleft_a = pleft_r;
    vleft_a = vleft_r;
    pseen_a = pseen_r;
    vseen_a = vseen_r;
    open_a  = open_r;

    if (is_sep) begin
      if (open_r) begin
        case (lp_r)
          bhsv_pkg::PH_MAGIC: begin
            lp_a = (mpos_r == bhsv_pkg::MAGIC_LEN) ? bhsv_pkg::PH_VERSION : bhsv_pkg::PH_FAIL;
          end
          bhsv_pkg::PH_VERSION: begin
            lp_a = (cp_r == bhsv_pkg::V_FZERO || cp_r == bhsv_pkg::V_FRAC) ?
                   bhsv_pkg::PH_PCOUNT : bhsv_pkg::PH_FAIL;
          end
          bhsv_pkg::PH_PCOUNT: begin
            if (acc_r == '0 || acc_r > CNT_MAX) begin
              lp_a = bhsv_pkg::PH_FAIL;
            end else begin
              pseen_a = acc_r;
              pleft_a = acc_r;
              lp_a    = bhsv_pkg::PH_VCOUNT;
            end
          end
          bhsv_pkg::PH_VCOUNT: begin
            if (acc_r > CNT_MAX || pleft_r <= acc_r) begin
              lp_a = bhsv_pkg::PH_FAIL;
            end else begin
              vseen_a = acc_r;
              pleft_a = pleft_dec;
              vleft_a = acc_r;
              if (pleft_dec == '0) begin
                lp_a = bhsv_pkg::PH_COMMENT;
              end else if (acc_r == '0) begin
                lp_a = bhsv_pkg::PH_PREDEF;
              end else begin
                lp_a = bhsv_pkg::PH_VARIANT;
              end
            end
          end
          bhsv_pkg::PH_VARIANT: begin
            vleft_a = vleft_dec;
            pleft_a = pleft_dec;
            if (vleft_dec == '0) begin
              lp_a = (pleft_dec == '0) ? bhsv_pkg::PH_COMMENT : bhsv_pkg::PH_PREDEF;
            end
          end
          bhsv_pkg::PH_PREDEF: begin
            if (cp_r == bhsv_pkg::P_SPACE) begin
              lp_a = bhsv_pkg::PH_FAIL;
            end else begin
              pleft_a = pleft_dec;
              if (pleft_dec == '0) begin
                lp_a = bhsv_pkg::PH_COMMENT;
              end
            end
          end
          default: begin
          end
        endcase
        open_a = 1'b0;
        cp_a   = '0;
        mpos_a = '0;
        acc_a  = '0;
      end
    end else begin
      open_a = 1'b1;
      case (lp_r)
        bhsv_pkg::PH_MAGIC: begin
          if (mpos_r < bhsv_pkg::MAGIC_LEN &&
              q_data.data == bhsv_pkg::magic_char(mpos_r[1:0])) begin
            mpos_a = mpos_r + 3'd1;
          end else begin
            lp_a = bhsv_pkg::PH_FAIL;
          end
        end
        bhsv_pkg::PH_VERSION: begin
          if (cp_r == bhsv_pkg::V_START || cp_r == bhsv_pkg::V_DOT) begin
            if (q_data.is_zero) begin
              cp_a = (cp_r == bhsv_pkg::V_START) ? bhsv_pkg::V_ZERO : bhsv_pkg::V_FZERO;
            end else if (q_data.is_nz) begin
              cp_a = (cp_r == bhsv_pkg::V_START) ? bhsv_pkg::V_INT : bhsv_pkg::V_FRAC;
            end else begin
              lp_a = bhsv_pkg::PH_FAIL;
            end
          end else if ((cp_r == bhsv_pkg::V_ZERO || cp_r == bhsv_pkg::V_INT) &&
                       q_data.is_dot) begin
            cp_a = bhsv_pkg::V_DOT;
          end else if (!((cp_r == bhsv_pkg::V_INT || cp_r == bhsv_pkg::V_FRAC) &&
                         q_data.is_dig)) begin
            lp_a = bhsv_pkg::PH_FAIL;
          end
        end
        bhsv_pkg::PH_PCOUNT, bhsv_pkg::PH_VCOUNT: begin
          if (cp_r == bhsv_pkg::N_START && q_data.is_dig) begin
            cp_a  = q_data.is_nz ? bhsv_pkg::N_DIG : bhsv_pkg::N_ZERO;
            acc_a = digit_acc;
          end else if (cp_r == bhsv_pkg::N_DIG && q_data.is_dig) begin
            acc_a = digit_acc;
          end else begin
            lp_a = bhsv_pkg::PH_FAIL;
          end
        end
        bhsv_pkg::PH_VARIANT: begin
          if (!q_data.var_ok) begin
            lp_a = bhsv_pkg::PH_FAIL;
          end
        end
        bhsv_pkg::PH_PREDEF: begin
          if (q_data.is_space) begin
            if (cp_r == bhsv_pkg::P_START) begin
              lp_a = bhsv_pkg::PH_FAIL;
            end else begin
              cp_a = bhsv_pkg::P_SPACE;
            end
          end else begin
            cp_a = bhsv_pkg::P_CHAR;
          end
        end
        default: begin
        end
      endcase
    end

    // The terminating zero byte rearms everything.
    if (q_data.is_end) begin
      lp_nxt    = bhsv_pkg::PH_MAGIC;
      cp_nxt    = '0;
      mpos_nxt  = '0;
      acc_nxt   = '0;
      pleft_nxt = '0;
      vleft_nxt = '0;
      pseen_nxt = '0;
      vseen_nxt = '0;
      open_nxt  = 1'b0;
    end else begin
      lp_nxt    = lp_a;
      cp_nxt    = cp_a;
      mpos_nxt  = mpos_a;
      acc_nxt   = acc_a;
      pleft_nxt = pleft_a;
      vleft_nxt = vleft_a;
      pseen_nxt = pseen_a;
      vseen_nxt = vseen_a;
      open_nxt  = open_a;
    end
  end

  // Result fields for this byte.
  always_comb begin
    vseen_ext = EW'(vseen_a);
    pseen_ext = EW'(pseen_a);
    res_nxt.section       = (is_sep || lp_r == bhsv_pkg::PH_FAIL) ?
                            bhsv_pkg::SECT_NONE : (3'(lp_r) + 3'd1);
    res_nxt.failed        = (lp_a == bhsv_pkg::PH_FAIL);
    res_nxt.end_of_header = q_data.is_end;
    res_nxt.header_ok     = q_data.is_end && (lp_a == bhsv_pkg::PH_COMMENT);
    res_nxt.variant_total = vseen_ext[9:0];
    res_nxt.predef_total  = pseen_ext[9:0];
    out_valid_nxt         = q_pop || (out_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r        <= bhsv_pkg::PH_MAGIC;
      cp_r        <= '0;
      mpos_r      <= '0;
      acc_r       <= '0;
      pleft_r     <= '0;
      vleft_r     <= '0;
      pseen_r     <= '0;
      vseen_r     <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        lp_r    <= lp_nxt;
        cp_r    <= cp_nxt;
        mpos_r  <= mpos_nxt;
        acc_r   <= acc_nxt;
        pleft_r <= pleft_nxt;
        vleft_r <= vleft_nxt;
        pseen_r <= pseen_nxt;
        vseen_r <= vseen_nxt;
        open_r  <= open_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

// File: design/book_header_stream_validator.sv
// ----------------------------------------------------------------------------
// book_header_stream_validator: streaming checker for a book header
// Parses a header text one byte per transaction, tags every byte with its
// section and reports acceptance of the header on its terminating zero byte.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Signals                          Content
//   input     in    in_tvalid/in_tready/in_tdata     one header byte
//   result    out   out_tvalid/out_tready/out_tdata  flags and count totals
//                   out_tuser, out_tlast             section tag, end of header
//
// The block sustains one transaction per cycle while the result side is ready.
// A byte is classified in the cycle it is accepted and waits in a two-entry
// queue; the parser takes it at the next edge at the earliest and loads its
// result into the output register at that same edge. The parser state update
// handles one byte at a time, and that loop sets the rate. Reset (rst_n low,
// synchronous) empties the queue and the output register and returns the
// parser to the start of a header. A stall on the result side fills the
// queue and then drops in_tready; no transaction is lost.
//
// Lines are checked in order: the magic line, a version line, a nonzero
// predef count, a variant count smaller than it, the variant lines and the
// remaining predef lines; anything after the last predef is comment. Empty
// lines are skipped. Any rejection is sticky until the zero byte, which
// reports header_ok and rearms the parser for the next header.
module book_header_stream_validator #(
  parameter int MAX_COUNT = 1023
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] failed, [1] header_ok,
                                  // [11:2] variant_total, [21:12] predef_total,
                                  // [23:22] zero
  output logic [2:0]  out_tuser,  // [2:0] section
  output logic        out_tlast   // end_of_header
);

  bhsv_pkg::cls_t in_cls;
  bhsv_pkg::cls_t q_data;
  bhsv_pkg::res_t res;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           push;

  // Front end: classify the byte as it arrives.
  bhsv_front u_front (
    .data_byte (in_tdata),
    .cls       (in_cls)
  );

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  bhsv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // Back end: the header parser with its result register.
  bhsv_back #(
    .MAX_COUNT (MAX_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {2'b00, res.predef_total, res.variant_total,
                      res.header_ok, res.failed};
  assign out_tuser = res.section;
  assign out_tlast = res.end_of_header;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for book_header_stream_validator
// Streams header text into the block one byte per transaction and checks
// every result transaction against a local line and character parser or a
// typed row. A short table of hand-picked bytes comes first. Random headers
// follow, most of them well formed with random content and the rest broken
// or noise, under several patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_COUNT   = 1023;
  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 215;
  localparam int LONG_HOLD   = 80;
  localparam int TAIL_CYCLES = 10;

  // Section tags carried on out_tuser.
  localparam logic [2:0] SEC_MAGIC   = 3'd1;
  localparam logic [2:0] SEC_VERSION = 3'd2;
  localparam logic [2:0] SEC_PCOUNT  = 3'd3;
  localparam logic [2:0] SEC_VCOUNT  = 3'd4;
  localparam logic [2:0] SEC_VARIANT = 3'd5;
  localparam logic [2:0] SEC_PREDEF  = 3'd6;
  localparam logic [2:0] SEC_COMMENT = 3'd7;

  // Byte classes used by the variant line check.
  localparam logic [7:0] PRINT_LO = 8'h21;
  localparam logic [7:0] PRINT_HI = 8'h7E;
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;

  // The magic line, first character in the lowest byte.
  localparam logic [31:0] MAGIC_WORD = 32'h4047_5040;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  book_header_stream_validator #(
    .MAX_COUNT(MAX_COUNT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),     // [7:0] data_byte
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),    // [0] failed, [1] header_ok, [11:2] variant_total,
                               // [21:12] predef_total, [23:22] zero
    .out_tuser (out_tuser),    // [2:0] section
    .out_tlast (out_tlast)     // end_of_header
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Parser model. It mirrors the header grammar: a line phase that walks
  // through the required lines and a character phase inside each line.
  // --------------------------------------------------------------------------
  bhsv_pkg::lp_t hdr_line      = bhsv_pkg::PH_MAGIC;
  bhsv_pkg::cp_t hdr_char      = bhsv_pkg::V_START;
  int unsigned   magic_idx     = 0;
  int unsigned   num_acc       = 0;
  int unsigned   predefs_todo  = 0;
  int unsigned   variants_todo = 0;
  int unsigned   predef_seen   = 0;
  int unsigned   variant_seen  = 0;
  bit            in_line       = 1'b0;
  bit            rejected      = 1'b0;

  // Expected result transactions, oldest first.
  bhsv_pkg::res_t expected_byte_results[$];

  int fail_count = 0;
  int sent_count = 0;
  int cycle_count = 0;

  // Idle percentages for the current phase of the run.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // A toggle on hold_req asks the sink process for one long hold-off.
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  function automatic void mark_reject();
    hdr_line = bhsv_pkg::PH_FAIL;
    rejected = 1'b1;
  endfunction

  // Counts saturate one above the limit so that an overflow stays visible.
  function automatic void add_count_digit(input logic [7:0] b);
    num_acc = num_acc * 10 + int'(b - bhsv_pkg::BYTE_ZERO);
    if (num_acc > MAX_COUNT) num_acc = MAX_COUNT + 1;
  endfunction

  function automatic void clear_parser();
    hdr_line      = bhsv_pkg::PH_MAGIC;
    hdr_char      = bhsv_pkg::V_START;
    magic_idx     = 0;
    num_acc       = 0;
    predefs_todo  = 0;
    variants_todo = 0;
    predef_seen   = 0;
    variant_seen  = 0;
    in_line       = 1'b0;
    rejected      = 1'b0;
  endfunction

  // Advances the parser by one byte and returns the result it should cause.
  task automatic tag_header_byte(input logic [7:0] b, output bhsv_pkg::res_t r);
    bit is_dig;
    bit is_nz;
    is_dig = (b >= bhsv_pkg::BYTE_ZERO && b <= bhsv_pkg::BYTE_NINE);
    is_nz  = is_dig && (b != bhsv_pkg::BYTE_ZERO);
    r = '0;
    if (b == bhsv_pkg::BYTE_END || b == bhsv_pkg::BYTE_NL) begin
      // A separator closes the open line, if any; empty lines change nothing.
      if (in_line) begin
        case (hdr_line)
          bhsv_pkg::PH_MAGIC: begin
            if (magic_idx == bhsv_pkg::MAGIC_LEN) hdr_line = bhsv_pkg::PH_VERSION;
            else mark_reject();
          end
          bhsv_pkg::PH_VERSION: begin
            if (hdr_char == bhsv_pkg::V_FZERO || hdr_char == bhsv_pkg::V_FRAC)
              hdr_line = bhsv_pkg::PH_PCOUNT;
            else mark_reject();
          end
          bhsv_pkg::PH_PCOUNT: begin
            if (num_acc == 0 || num_acc > MAX_COUNT) begin
              mark_reject();
            end else begin
              predef_seen  = num_acc;
              predefs_todo = num_acc;
              hdr_line     = bhsv_pkg::PH_VCOUNT;
            end
          end
          bhsv_pkg::PH_VCOUNT: begin
            // The variant count line itself uses up one predef.
            if (num_acc > MAX_COUNT || predefs_todo <= num_acc) begin
              mark_reject();
            end else begin
              variant_seen  = num_acc;
              predefs_todo  = predefs_todo - 1;
              variants_todo = num_acc;
              if (predefs_todo == 0) hdr_line = bhsv_pkg::PH_COMMENT;
              else if (num_acc == 0) hdr_line = bhsv_pkg::PH_PREDEF;
              else hdr_line = bhsv_pkg::PH_VARIANT;
            end
          end
          bhsv_pkg::PH_VARIANT: begin
            variants_todo = variants_todo - 1;
            predefs_todo  = predefs_todo - 1;
            if (variants_todo == 0)
              hdr_line = (predefs_todo == 0) ? bhsv_pkg::PH_COMMENT : bhsv_pkg::PH_PREDEF;
          end
          bhsv_pkg::PH_PREDEF: begin
            if (hdr_char == bhsv_pkg::P_SPACE) begin
              mark_reject();
            end else begin
              predefs_todo = predefs_todo - 1;
              if (predefs_todo == 0) hdr_line = bhsv_pkg::PH_COMMENT;
            end
          end
          default: ;
        endcase
        // Every character phase restarts from zero on a new line.
        in_line   = 1'b0;
        hdr_char  = bhsv_pkg::V_START;
        magic_idx = 0;
        num_acc   = 0;
      end
      if (b == bhsv_pkg::BYTE_END) begin
        r.end_of_header = 1'b1;
        r.header_ok     = (hdr_line == bhsv_pkg::PH_COMMENT) && !rejected;
      end
    end else begin
      if (hdr_line != bhsv_pkg::PH_FAIL) r.section = 3'(hdr_line) + 3'd1;
      in_line = 1'b1;
      case (hdr_line)
        bhsv_pkg::PH_MAGIC: begin
          if (magic_idx < bhsv_pkg::MAGIC_LEN && b == MAGIC_WORD[8 * magic_idx +: 8])
            magic_idx = magic_idx + 1;
          else
            mark_reject();
        end
        bhsv_pkg::PH_VERSION: begin
          // Neither part of the version may carry a leading zero.
          if (hdr_char == bhsv_pkg::V_START || hdr_char == bhsv_pkg::V_DOT) begin
            if (b == bhsv_pkg::BYTE_ZERO)
              hdr_char = (hdr_char == bhsv_pkg::V_START) ? bhsv_pkg::V_ZERO
                                                         : bhsv_pkg::V_FZERO;
            else if (is_nz)
              hdr_char = (hdr_char == bhsv_pkg::V_START) ? bhsv_pkg::V_INT
                                                         : bhsv_pkg::V_FRAC;
            else mark_reject();
          end else if ((hdr_char == bhsv_pkg::V_ZERO || hdr_char == bhsv_pkg::V_INT) &&
                       b == bhsv_pkg::BYTE_DOT) begin
            hdr_char = bhsv_pkg::V_DOT;
          end else if (!((hdr_char == bhsv_pkg::V_INT || hdr_char == bhsv_pkg::V_FRAC) &&
                         is_dig)) begin
            mark_reject();
          end
        end
        bhsv_pkg::PH_PCOUNT, bhsv_pkg::PH_VCOUNT: begin
          if (hdr_char == bhsv_pkg::N_START && is_dig) begin
            hdr_char = is_nz ? bhsv_pkg::N_DIG : bhsv_pkg::N_ZERO;
            add_count_digit(b);
          end else if (hdr_char == bhsv_pkg::N_DIG && is_dig) begin
            add_count_digit(b);
          end else begin
            mark_reject();
          end
        end
        bhsv_pkg::PH_VARIANT: begin
          if (b < PRINT_LO || b > PRINT_HI || (b >= UPPER_A && b <= UPPER_Z)) mark_reject();
        end
        bhsv_pkg::PH_PREDEF: begin
          if (b == bhsv_pkg::BYTE_SPACE) begin
            if (hdr_char == bhsv_pkg::P_START) mark_reject();
            else hdr_char = bhsv_pkg::P_SPACE;
          end else begin
            hdr_char = bhsv_pkg::P_CHAR;
          end
        end
        default: ;
      endcase
    end
    r.failed        = rejected;
    r.variant_total = variant_seen[9:0];
    r.predef_total  = predef_seen[9:0];
    if (b == bhsv_pkg::BYTE_END) clear_parser();
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Rows with typed set carry an expectation written out by
  // hand; the remaining rows are checked against the parser model.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic [2:0] section;
    logic       failed;
    logic       eoh;
    logic       ok;
    logic [9:0] vtot;
    logic [9:0] ptot;
  } dir_row_t;

  localparam int DIR_ROWS = 19;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // An empty header right after reset is not accepted, but not failed.
    '{bhsv_pkg::BYTE_END,  1'b1, bhsv_pkg::SECT_NONE, 1'b0, 1'b1, 1'b0, 10'd0, 10'd0},
    // Smallest accepted header: magic, version 0.0, one predef, no variants.
    '{8'h40,               1'b1, SEC_MAGIC,           1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{8'h50,               1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{8'h47,               1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{8'h40,               1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_NL,   1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_ZERO, 1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_DOT,  1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_ZERO, 1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_NL,   1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{8'h31,               1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_NL,   1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_ZERO, 1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_NL,   1'b0, bhsv_pkg::SECT_NONE, 1'b0, 1'b0, 1'b0, 10'd0, 10'd0},
    // All-ones byte in the comment section.
    '{8'hFF,               1'b1, SEC_COMMENT,         1'b0, 1'b0, 1'b0, 10'd0, 10'd1},
    '{bhsv_pkg::BYTE_END,  1'b1, bhsv_pkg::SECT_NONE, 1'b0, 1'b1, 1'b1, 10'd0, 10'd1},
    // A wrong first byte rejects the header; the flag sticks to the end.
    '{8'hFF,               1'b1, SEC_MAGIC,           1'b1, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_NL,   1'b1, bhsv_pkg::SECT_NONE, 1'b1, 1'b0, 1'b0, 10'd0, 10'd0},
    '{bhsv_pkg::BYTE_END,  1'b1, bhsv_pkg::SECT_NONE, 1'b1, 1'b1, 1'b0, 10'd0, 10'd0}
  };

  // --------------------------------------------------------------------------
  // Random header construction.
  // --------------------------------------------------------------------------
  logic [7:0] hdr_text[$];

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr_text.push_back(s[i]);
  endtask

  // Ends a line and now and then adds a blank line, which the block skips.
  task automatic end_text_line();
    hdr_text.push_back(bhsv_pkg::BYTE_NL);
    if ($urandom_range(0, 9) == 0) hdr_text.push_back(bhsv_pkg::BYTE_NL);
  endtask

  // Any byte that neither ends a line nor ends the header.
  function automatic logic [7:0] any_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == bhsv_pkg::BYTE_NL);
    return b;
  endfunction

  function automatic logic [7:0] variant_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(PRINT_LO, PRINT_HI)); while (b >= UPPER_A && b <= UPPER_Z);
    return b;
  endfunction

  function automatic logic [7:0] predef_byte(input bit space_ok);
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 4) == 0) ? bhsv_pkg::BYTE_SPACE : any_text_byte();
    end while (!space_ok && b == bhsv_pkg::BYTE_SPACE);
    return b;
  endfunction

  task automatic build_header();
    int pick;
    int p_cnt;
    int v_cnt;
    int budget;
    int n;
    int major;
    int minor;
    hdr_text.delete();
    if ($urandom_range(0, 11) == 0) begin
      // Plain noise, which the magic line check should reject at once.
      n = $urandom_range(1, 24);
      repeat (n) hdr_text.push_back(8'($urandom_range(1, 255)));
    end else begin
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
        add_text("@PG");
      end else if (pick == 1) begin
        add_text("@PG@@");
      end else if (pick == 2) begin
        add_text("@PG@");
        hdr_text[$urandom_range(0, 3)] = any_text_byte();
      end else begin
        add_text("@PG@");
      end
      if ($urandom_range(0, 9) == 0) hdr_text.push_front(bhsv_pkg::BYTE_NL);
      end_text_line();

      major = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 999);
      minor = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 999);
      case ($urandom_range(0, 29))
        0:       add_text($sformatf("0%0d.%0d", $urandom_range(0, 99), minor));
        1:       add_text($sformatf("%0d", major));
        2:       add_text($sformatf("%0d.", major));
        3:       add_text($sformatf("%0d.0%0d", major, $urandom_range(0, 9)));
        4:       add_text($sformatf("%0d.%0dv", major, minor));
        default: add_text($sformatf("%0d.%0d", major, minor));
      endcase
      end_text_line();

      case ($urandom_range(0, 19))
        0:       p_cnt = 0;
        1:       p_cnt = MAX_COUNT;
        2:       p_cnt = MAX_COUNT + 1;
        3:       p_cnt = $urandom_range(MAX_COUNT + 2, 99999);
        default: p_cnt = $urandom_range(1, 8);
      endcase
      if ($urandom_range(0, 24) == 0) add_text("0");
      add_text($sformatf("%0d", p_cnt));
      end_text_line();

      if ($urandom_range(0, 14) == 0) v_cnt = p_cnt + $urandom_range(0, 2);
      else if (p_cnt == 0) v_cnt = 0;
      else v_cnt = $urandom_range(0, ((p_cnt > MAX_COUNT) ? MAX_COUNT : p_cnt) - 1);
      if ($urandom_range(0, 24) == 0) add_text("0");
      add_text($sformatf("%0d", v_cnt));
      end_text_line();

      // Large counts would take hundreds of lines, so those headers stop early.
      budget = (p_cnt > 12) ? $urandom_range(0, 4) : p_cnt;
      for (int i = 0; i < p_cnt - 1 && i < budget; i++) begin
        n = $urandom_range(1, 6);
        if (i < v_cnt) begin
          repeat (n) hdr_text.push_back(variant_byte());
          if ($urandom_range(0, 39) == 0) hdr_text.push_back(any_text_byte());
        end else begin
          pick = $urandom_range(0, 59);
          if (pick == 0) hdr_text.push_back(bhsv_pkg::BYTE_SPACE);
          hdr_text.push_back(predef_byte(1'b0));
          for (int k = 1; k < n; k++) hdr_text.push_back(predef_byte(k < n - 1));
          if (pick == 1) hdr_text.push_back(bhsv_pkg::BYTE_SPACE);
        end
        end_text_line();
      end

      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(1, 8)) hdr_text.push_back(any_text_byte());
        end_text_line();
      end

      // Now and then the header is abandoned part way, possibly empty.
      if ($urandom_range(0, 24) == 0) begin
        n = $urandom_range(0, hdr_text.size());
        while (hdr_text.size() > n) void'(hdr_text.pop_back());
      end
      // The zero byte must also close a line that has no newline of its own.
      if (hdr_text.size() > 0 && $urandom_range(0, 3) == 0 &&
          hdr_text[$] == bhsv_pkg::BYTE_NL)
        void'(hdr_text.pop_back());
    end
    hdr_text.push_back(bhsv_pkg::BYTE_END);
  endtask

  // --------------------------------------------------------------------------
  // Source side. The byte stays on the bus until the block takes it; the
  // model is advanced at the edge where the transaction happens.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit use_typed,
                           input bhsv_pkg::res_t typed_res);
    bhsv_pkg::res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tag_header_byte(b, predicted);
    expected_byte_results.push_back(use_typed ? typed_res : predicted);
    sent_count++;
  endtask

  // Holds the source back until every expected result has been seen.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_byte_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sink side. Random back-pressure, plus one long hold-off on request that
  // lets the block fill up and drop in_tready.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    bhsv_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_byte_results.size() == 0) begin
        $display("%0t: result with nothing expected: tdata %h tuser %0d tlast %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = expected_byte_results.pop_front();
        check_field("section",       want.section,       out_tuser);
        check_field("failed",        want.failed,        out_tdata[0]);
        check_field("header_ok",     want.header_ok,     out_tdata[1]);
        check_field("variant_total", want.variant_total, out_tdata[11:2]);
        check_field("predef_total",  want.predef_total,  out_tdata[21:12]);
        check_field("end_of_header", want.end_of_header, out_tlast);
        check_field("tdata padding", 0,                  out_tdata[23:22]);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then random headers in phases
  // of different idling, each phase drained before the next one starts.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bhsv_pkg::res_t typed;
    int             phase_end;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      typed               = '0;
      typed.section       = dir_rows[i].section;
      typed.failed        = dir_rows[i].failed;
      typed.end_of_header = dir_rows[i].eoh;
      typed.header_ok     = dir_rows[i].ok;
      typed.variant_total = dir_rows[i].vtot;
      typed.predef_total  = dir_rows[i].ptot;
      send_byte(dir_rows[i].data, dir_rows[i].typed, typed);
    end
    wait_results_drained();

    for (int round = 0; round < 2; round++) begin
      for (int mode = 0; mode < 4; mode++) begin
        case (mode)
          0: begin
            // No idling at all; the sink also takes one long break while the
            // source keeps offering bytes.
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_req      <= ~hold_req;
          end
          1: begin
            send_idle_pct  = 58;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 58;
          end
          default: begin
            send_idle_pct  = 6;
            recv_stall_pct = 6;
          end
        endcase
        phase_end = sent_count + PHASE_ITEMS;
        while (sent_count < phase_end) begin
          build_header();
          foreach (hdr_text[k]) send_byte(hdr_text[k], 1'b0, '0);
        end
        wait_results_drained();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bhsv_pkg.sv
design/bhsv_front.sv
design/bhsv_queue.sv
design/bhsv_back.sv
design/book_header_stream_validator.sv
test/tb.sv
